>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int REGIONS       = 4;
  localparam int REGION_FRAMES = 4096;
  localparam int FRAME_BYTES   = 4096;
  localparam int WORD_BITS     = 64;
  localparam int REGION_WORDS  = REGION_FRAMES / WORD_BITS;
  localparam int MAP_WORDS     = REGIONS * REGION_WORDS;

  localparam int ADDR_W     = 52;
  localparam int OFF_W      = $clog2(FRAME_BYTES);
  localparam int PAGE_W     = ADDR_W - OFF_W;
  localparam int FRAMES_W   = 13;
  localparam int FRAME_W    = $clog2(REGION_FRAMES);
  localparam int REG_W      = $clog2(REGIONS);
  localparam int WIDX_W     = $clog2(REGION_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int CFG_IDX_W  = 3;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_OUTSIDE    = 2'd2,
    ST_MISALIGNED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_BASE   = 3'd0,
    CFG_R0_FRAMES = 3'd1,
    CFG_R1_BASE   = 3'd2,
    CFG_R1_FRAMES = 3'd3,
    CFG_R2_BASE   = 3'd4,
    CFG_R2_FRAMES = 3'd5,
    CFG_R3_BASE   = 3'd6,
    CFG_R3_FRAMES = 3'd7
  } cfg_reg_e;

  // View of the currently selected region.
  typedef struct packed {
    logic [FRAMES_W-1:0] usable;  // frames that may be handed out
    logic [PAGE_W-1:0]   pn;      // page number of the region base
    logic                hit;     // request page lies inside the region
    logic [FRAME_W-1:0]  frame;   // frame index of the request page
  } region_info_t;

  // Word operations on one bitmap word.
  typedef struct packed {
    logic [WORD_BITS-1:0] free;       // free and usable bits of the read word
    logic                 any_free;
    logic                 more_words; // region continues past this word
    logic [WORD_BITS-1:0] first_oh;   // lowest free bit as one-hot
    logic [BIT_W-1:0]     first_idx;
    logic [WORD_BITS-1:0] run_mask;   // bits of a reserve run in this word
    logic [FRAMES_W-1:0]  next_cur;   // first frame of the next word
  } bits_res_t;

endpackage

>>> rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page-frame allocator over four regions with a 256-word bitmap.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// s_axis   in         tuser: req_type; tdata: req_addr [51:0], frame_count [64:52]
// m_axis   out        tuser: status; tdata: frame_addr [51:0]
// cfg      in         cfg_index_i selects a region register, cfg_data_i the value
//
// One request at a time; the sequencer walks regions one per cycle apart from
// the word scan of an allocate, and handles each bitmap word as a registered RAM
// read followed by a write or check. Allocate takes the first free bit; free
// clears the bit of one page; reserve sets a run of bits word by word.
// The bitmap reads as all free after reset through per-word valid bits.
// A pending result is held in the output register while the next item enters.
module bitmap_frame_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [71:0]                       s_axis_tdata, // req_addr, frame_count
  input  logic [1:0]                        s_axis_tuser, // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [55:0]                       m_axis_tdata, // frame_addr
  output logic [1:0]                        m_axis_tuser, // status
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfa_pkg::ADDR_W-1:0]        cfg_data_i
);
  import bfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_REG, S_A_RD, S_A_CHK, S_A_FIND, S_A_ADDR,
    S_LOC, S_F_RD, S_F_WR, S_R_CHK, S_R_RD, S_R_WR, S_DONE
  } state_e;

  state_e state_q;
  logic [REGIONS-1:0][ADDR_W-1:0]   base_q;
  logic [REGIONS-1:0][FRAMES_W-1:0] frames_q;
  req_e                kind_q;
  logic [PAGE_W-1:0]   page_q;
  logic [FRAMES_W-1:0] count_q;
  logic [REG_W-1:0]    r_q;
  logic [WIDX_W-1:0]   w_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [FRAMES_W-1:0] usable_q;
  logic [FRAMES_W-1:0] cur_q;
  logic [FRAMES_W-1:0] end_q;
  logic [WORD_BITS-1:0] free_q;
  logic [WORD_BITS-1:0] word_q;
  status_e             res_status_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [MAP_WORDS-1:0] valid_q;
  logic                rd_vld_q;

  region_info_t        rinfo;
  bits_res_t           bres;
  logic                ram_we;
  logic [MAP_AW-1:0]   ram_waddr;
  logic [MAP_AW-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] rd_word;
  logic [FRAMES_W:0]   run_end;
  logic                last_region;
  logic                in_take;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'b0, out_addr_q};
  assign rd_word       = rd_vld_q ? ram_rdata : '0;
  assign run_end       = (FRAMES_W+1)'(frame_q) + (FRAMES_W+1)'(count_q);
  assign last_region   = (r_q == REG_W'(REGIONS - 1));

  bfa_region u_region (
    .region_i (r_q),
    .base_i   (base_q),
    .frames_i (frames_q),
    .page_i   (page_q),
    .info_o   (rinfo)
  );

  bfa_bits u_bits (
    .word_i   (rd_word),
    .widx_i   (w_q),
    .usable_i (usable_q),
    .free_i   (free_q),
    .cur_i    (cur_q),
    .end_i    (end_q),
    .res_o    (bres)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {r_q, w_q};
    ram_wdata = word_q | bres.first_oh;
    ram_raddr = {r_q, w_q};
    unique case (state_q)
      S_A_FIND: begin
        ram_we = 1'b1;
      end
      S_F_RD: begin
        ram_raddr = {r_q, frame_q[FRAME_W-1:BIT_W]};
      end
      S_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {r_q, frame_q[FRAME_W-1:BIT_W]};
        ram_wdata = rd_word & ~(WORD_BITS'(1) << frame_q[BIT_W-1:0]);
      end
      S_R_RD: begin
        ram_raddr = {r_q, cur_q[FRAME_W-1:BIT_W]};
      end
      S_R_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {r_q, cur_q[FRAME_W-1:BIT_W]};
        ram_wdata = rd_word | bres.run_mask;
      end
      default: begin
      end
    endcase
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      frames_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_R0_BASE:   base_q[0]   <= cfg_data_i;
        CFG_R0_FRAMES: frames_q[0] <= cfg_data_i[FRAMES_W-1:0];
        CFG_R1_BASE:   base_q[1]   <= cfg_data_i;
        CFG_R1_FRAMES: frames_q[1] <= cfg_data_i[FRAMES_W-1:0];
        CFG_R2_BASE:   base_q[2]   <= cfg_data_i;
        CFG_R2_FRAMES: frames_q[2] <= cfg_data_i[FRAMES_W-1:0];
        CFG_R3_BASE:   base_q[3]   <= cfg_data_i;
        CFG_R3_FRAMES: frames_q[3] <= cfg_data_i[FRAMES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= REQ_ALLOC;
      page_q       <= '0;
      count_q      <= '0;
      r_q          <= '0;
      w_q          <= '0;
      frame_q      <= '0;
      usable_q     <= '0;
      cur_q        <= '0;
      end_q        <= '0;
      free_q       <= '0;
      word_q       <= '0;
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_addr_q   <= '0;
    end else begin
      // In the done state the output register is reloaded instead.
      if (m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            kind_q       <= req_e'(s_axis_tuser);
            page_q       <= s_axis_tdata[ADDR_W-1:OFF_W];
            count_q      <= s_axis_tdata[ADDR_W+FRAMES_W-1:ADDR_W];
            r_q          <= '0;
            w_q          <= '0;
            res_addr_q   <= '0;
            res_status_q <= ST_OK;
            case (req_e'(s_axis_tuser))
              REQ_ALLOC: state_q <= S_A_REG;
              REQ_FREE, REQ_RESERVE: begin
                if (s_axis_tdata[OFF_W-1:0] != '0) begin
                  res_status_q <= ST_MISALIGNED;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_LOC;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_A_REG: begin
          usable_q <= rinfo.usable;
          w_q      <= '0;
          if (rinfo.usable != '0) begin
            state_q <= S_A_RD;
          end else if (last_region) begin
            res_status_q <= ST_NO_FREE;
            state_q      <= S_DONE;
          end else begin
            r_q <= r_q + REG_W'(1);
          end
        end
        S_A_RD: begin
          state_q <= S_A_CHK;
        end
        S_A_CHK: begin
          if (bres.any_free) begin
            free_q  <= bres.free;
            word_q  <= rd_word;
            state_q <= S_A_FIND;
          end else if (bres.more_words) begin
            w_q     <= w_q + WIDX_W'(1);
            state_q <= S_A_RD;
          end else if (last_region) begin
            res_status_q <= ST_NO_FREE;
            state_q      <= S_DONE;
          end else begin
            r_q     <= r_q + REG_W'(1);
            state_q <= S_A_REG;
          end
        end
        S_A_FIND: begin
          frame_q <= {w_q, bres.first_idx};
          state_q <= S_A_ADDR;
        end
        S_A_ADDR: begin
          res_addr_q <= {rinfo.pn + PAGE_W'(frame_q), {OFF_W{1'b0}}};
          state_q    <= S_DONE;
        end
        S_LOC: begin
          if (rinfo.hit) begin
            frame_q  <= rinfo.frame;
            usable_q <= rinfo.usable;
            state_q  <= (kind_q == REQ_FREE) ? S_F_RD : S_R_CHK;
          end else if (last_region) begin
            res_status_q <= ST_OUTSIDE;
            state_q      <= S_DONE;
          end else begin
            r_q <= r_q + REG_W'(1);
          end
        end
        S_F_RD: begin
          state_q <= S_F_WR;
        end
        S_F_WR: begin
          state_q <= S_DONE;
        end
        S_R_CHK: begin
          cur_q <= FRAMES_W'(frame_q);
          end_q <= run_end[FRAMES_W-1:0];
          if (run_end > (FRAMES_W+1)'(usable_q)) begin
            res_status_q <= ST_OUTSIDE;
            state_q      <= S_DONE;
          end else if (count_q == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_R_RD;
          end
        end
        S_R_RD: begin
          state_q <= S_R_WR;
        end
        S_R_WR: begin
          cur_q   <= bres.next_cur;
          state_q <= (bres.next_cur >= end_q) ? S_DONE : S_R_RD;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_addr_q   <= res_addr_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The word check always sees the data of the read issued just before it.
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_CHK) |-> ($past(state_q) == S_A_RD))
    else $error("word check without a preceding read");

  // A found word must hold at least one free bit.
  a_find_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_FIND) |-> (free_q != '0))
    else $error("allocation picked a word with no free bit");

  // A reserve write stays inside the run.
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_WR) |-> (cur_q < end_q))
    else $error("reserve write past the end of the run");

  // Every written word reads back as written, not as its reset value.
  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(ram_waddr)])
    else $error("written bitmap word not marked valid");

endmodule

>>> rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfa_region.sv
// ----------------------------------------------------------------------------
// bfa_region
// Region unit: usable frame count of one region and the range check of a page.
// ----------------------------------------------------------------------------
module bfa_region (
  input  logic [bfa_pkg::REG_W-1:0]                           region_i,
  input  logic [bfa_pkg::REGIONS-1:0][bfa_pkg::ADDR_W-1:0]    base_i,
  input  logic [bfa_pkg::REGIONS-1:0][bfa_pkg::FRAMES_W-1:0]  frames_i,
  input  logic [bfa_pkg::PAGE_W-1:0]                          page_i,
  output bfa_pkg::region_info_t                               info_o
);
  import bfa_pkg::*;

  logic [PAGE_W-1:0]   pn;
  logic [FRAMES_W-1:0] cnt;
  logic [PAGE_W:0]     room;
  logic [PAGE_W:0]     diff;
  logic [FRAMES_W-1:0] usable;

  always_comb begin
    pn  = base_i[region_i][ADDR_W-1:OFF_W];
    cnt = frames_i[region_i];
    if (cnt > FRAMES_W'(REGION_FRAMES)) begin
      cnt = FRAMES_W'(REGION_FRAMES);
    end
    // Frames must end within the address space.
    room = {1'b1, {PAGE_W{1'b0}}} - {1'b0, pn};
    if (room < (PAGE_W+1)'(cnt)) begin
      usable = room[FRAMES_W-1:0];
    end else begin
      usable = cnt;
    end
    diff = {1'b0, page_i} - {1'b0, pn};
    info_o.usable = usable;
    info_o.pn     = pn;
    info_o.hit    = (usable != '0) && !diff[PAGE_W] &&
                    (diff[PAGE_W-1:0] < PAGE_W'(usable));
    info_o.frame  = diff[FRAME_W-1:0];
  end

endmodule

>>> rtl/bfa_bits.sv
// ----------------------------------------------------------------------------
// bfa_bits
// Word unit: free-bit search and reserve-run masks for one bitmap word.
// ----------------------------------------------------------------------------
module bfa_bits (
  input  logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [bfa_pkg::WIDX_W-1:0]    widx_i,
  input  logic [bfa_pkg::FRAMES_W-1:0]  usable_i,
  input  logic [bfa_pkg::WORD_BITS-1:0] free_i,
  input  logic [bfa_pkg::FRAMES_W-1:0]  cur_i,
  input  logic [bfa_pkg::FRAMES_W-1:0]  end_i,
  output bfa_pkg::bits_res_t            res_o
);
  import bfa_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [FRAMES_W-1:0]  next_w;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] oh;
  logic [BIT_W-1:0]     idx;
  logic [FRAMES_W-1:0]  next_c;
  logic [WORD_BITS-1:0] hi_mask;

  always_comb begin
    next_w = {(WIDX_W+1)'(widx_i) + (WIDX_W+1)'(1), {BIT_W{1'b0}}};
    // Bits at or past the usable count count as used.
    if (usable_i < next_w) begin
      vmask = ~(ONES << usable_i[BIT_W-1:0]);
    end else begin
      vmask = ONES;
    end
    res_o.free       = ~word_i & vmask;
    res_o.any_free   = (res_o.free != '0);
    res_o.more_words = (next_w < usable_i);

    oh  = free_i & (~free_i + WORD_BITS'(1));
    idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (oh[k]) begin
        idx = idx | BIT_W'(k);
      end
    end
    res_o.first_oh  = oh;
    res_o.first_idx = idx;

    next_c = {cur_i[FRAMES_W-1:BIT_W] + (FRAMES_W-BIT_W)'(1), {BIT_W{1'b0}}};
    if (end_i >= next_c) begin
      hi_mask = ONES;
    end else begin
      hi_mask = ~(ONES << end_i[BIT_W-1:0]);
    end
    res_o.run_mask = (ONES << cur_i[BIT_W-1:0]) & hi_mask;
    res_o.next_cur = next_c;
  end

endmodule
